[rtl/core/rmeyxz_pkg.sv]
// ----------------------------------------------------------------------------
// rmeyxz_pkg
// Types, constants and arithmetic helpers for the Y-X-Z Euler angle pipeline.
// ----------------------------------------------------------------------------
package rmeyxz_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SQ_STAGES     = 29;
  localparam int CW            = 34;
  localparam int ZW            = 32;
  localparam int NW            = 2 * SQ_STAGES;
  localparam int RW            = 32;
  localparam logic signed [15:0] Q_ONE = 16'sd16384;
  localparam int XLIM          = 90 * 128;
  localparam int YLIM          = 180 * 128;
  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);

  typedef struct packed {
    logic signed [15:0] r12;
    logic signed [15:0] r02;
    logic signed [15:0] r22;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r01;
    logic signed [15:0] r00;
  } in_t;

  typedef struct packed {
    logic signed [14:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               gimbal_lock;
  } out_t;

  typedef struct packed {
    logic               lock;
    logic               xneg;
    logic signed [15:0] c12;
    logic signed [15:0] ya;
    logic signed [15:0] xa;
    logic signed [15:0] zy;
    logic signed [15:0] zx;
  } front_t;

  typedef struct packed {
    front_t          f;
    logic [NW-1:0]   n;
    logic [RW-1:0]   rem;
    logic [SQ_STAGES-1:0] res;
  } sq_t;

  typedef struct packed {
    logic               zr;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  typedef struct packed {
    logic  lock;
    logic  xneg;
    lane_t lx;
    lane_t ly;
    lane_t lz;
  } cd_t;

  function automatic logic signed [ZW-1:0] arc_at(input int i);
    case (i)
      0:  return ZW'(2949120);
      1:  return ZW'(1740967);
      2:  return ZW'(919879);
      3:  return ZW'(466945);
      4:  return ZW'(234379);
      5:  return ZW'(117304);
      6:  return ZW'(58666);
      7:  return ZW'(29335);
      8:  return ZW'(14668);
      9:  return ZW'(7334);
      10: return ZW'(3667);
      11: return ZW'(1833);
      12: return ZW'(917);
      13: return ZW'(458);
      14: return ZW'(229);
      15: return ZW'(115);
      16: return ZW'(57);
      17: return ZW'(29);
      18: return ZW'(14);
      19: return ZW'(7);
      20: return ZW'(4);
      21: return ZW'(2);
      22: return ZW'(1);
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [15:0] clamp_q(input logic signed [15:0] v);
    if (v < -Q_ONE) return -Q_ONE;
    if (v > Q_ONE) return Q_ONE;
    return v;
  endfunction

  function automatic logic signed [CW-1:0] widen_q(input logic signed [15:0] v);
    logic signed [CW-1:0] w;
    w = {{(CW-16){v[15]}}, v};
    return w <<< 14;
  endfunction

  function automatic lane_t fold(input logic signed [CW-1:0] y,
                                 input logic signed [CW-1:0] x);
    lane_t l;
    l.zr = (y == '0) && (x == '0);
    l.x  = x;
    l.y  = y;
    l.z  = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = DEG90;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -DEG90;
      end
    end
    return l;
  endfunction

  function automatic lane_t rot(input lane_t a, input int i);
    lane_t b;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = a.y >>> i;
    dy = a.x >>> i;
    b  = a;
    if (a.y > 0) begin
      b.x = a.x + dx;
      b.y = a.y - dy;
      b.z = a.z + arc_at(i);
    end else begin
      b.x = a.x - dx;
      b.y = a.y + dy;
      b.z = a.z - arc_at(i);
    end
    return b;
  endfunction

  function automatic logic signed [15:0] to_out(input lane_t l, input int lim);
    logic signed [ZW-1:0] r;
    logic signed [ZW-1:0] lm;
    lm = ZW'(lim);
    r  = (l.z + ZW'(256)) >>> 9;
    if (l.zr) r = '0;
    if (r > lm) r = lm;
    if (r < -lm) r = -lm;
    return r[15:0];
  endfunction

endpackage

[rtl/core/rotation_matrix_to_euler_yxz.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_yxz
// Throughput: one beat per cycle; the pipeline holds only while a
// result waits at the output. The square root takes one result bit a stage.
// Reset: rst_n synchronous, active low, clears every valid bit.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_yxz (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmeyxz_pkg::in_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rmeyxz_pkg::out_t    out_data
);
  import rmeyxz_pkg::*;

  logic   en;
  front_t fa_nxt, fa_r;
  logic   fa_v_r;
  front_t fb_r;
  logic [SQ_STAGES-1:0] mb_r;
  logic   fb_v_r;
  sq_t    sq_nxt [SQ_STAGES];
  sq_t    sq_r   [SQ_STAGES];
  logic [SQ_STAGES-1:0] sq_v_r;
  cd_t    cd_nxt [CORDIC_STAGES+1];
  cd_t    cd_r   [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] cd_v_r;
  out_t   out_nxt, out_r;
  logic   out_valid_r;
  logic signed [31:0] sqr;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic signed [15:0] c12, c01;
    c12         = clamp_q(in_data.r12);
    c01         = clamp_q(in_data.r01);
    fa_nxt.c12  = c12;
    fa_nxt.lock = (c12 == Q_ONE) || (c12 == -Q_ONE);
    fa_nxt.xneg = (c12 == Q_ONE);
    fa_nxt.ya   = fa_nxt.lock ? -c01 : clamp_q(in_data.r02);
    fa_nxt.xa   = fa_nxt.lock ? clamp_q(in_data.r00) : clamp_q(in_data.r22);
    fa_nxt.zy   = clamp_q(in_data.r10);
    fa_nxt.zx   = clamp_q(in_data.r11);
  end

  assign sqr = fa_r.c12 * fa_r.c12;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    always_comb begin
      sq_t          a;
      logic [RW-1:0] r;
      logic [RW-1:0] t;
      if (k == 0) begin
        a.f   = fb_r;
        a.n   = {1'b0, mb_r, {(NW-SQ_STAGES-1){1'b0}}};
        a.rem = '0;
        a.res = '0;
      end else begin
        a = sq_r[(k == 0) ? 0 : k-1];
      end
      r = {a.rem[RW-3:0], a.n[NW-1:NW-2]};
      t = {1'b0, a.res, 2'b01};
      sq_nxt[k]   = a;
      sq_nxt[k].n = {a.n[NW-3:0], 2'b00};
      if (r >= t) begin
        sq_nxt[k].rem = r - t;
        sq_nxt[k].res = {a.res[SQ_STAGES-2:0], 1'b1};
      end else begin
        sq_nxt[k].rem = r;
        sq_nxt[k].res = {a.res[SQ_STAGES-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sq_t a;
    a = sq_r[SQ_STAGES-1];
    cd_nxt[0].lock = a.f.lock;
    cd_nxt[0].xneg = a.f.xneg;
    cd_nxt[0].lx   = fold(widen_q(-a.f.c12), CW'({1'b0, a.res}));
    cd_nxt[0].ly   = fold(widen_q(a.f.ya), widen_q(a.f.xa));
    cd_nxt[0].lz   = fold(widen_q(a.f.zy), widen_q(a.f.zx));
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cd
    always_comb begin
      cd_nxt[j+1]    = cd_r[j];
      cd_nxt[j+1].lx = rot(cd_r[j].lx, j);
      cd_nxt[j+1].ly = rot(cd_r[j].ly, j);
      cd_nxt[j+1].lz = rot(cd_r[j].lz, j);
    end
  end

  always_comb begin
    cd_t a;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
    a  = cd_r[CORDIC_STAGES];
    ay = to_out(a.ly, YLIM);
    ax = to_out(a.lx, XLIM);
    out_nxt.gimbal_lock = a.lock;
    if (a.lock) begin
      out_nxt.angle_x = a.xneg ? -15'(XLIM) : 15'(XLIM);
      out_nxt.angle_y = a.xneg ? -ay : ay;
      out_nxt.angle_z = '0;
    end else begin
      out_nxt.angle_x = ax[14:0];
      out_nxt.angle_y = ay;
      out_nxt.angle_z = to_out(a.lz, YLIM);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_v_r      <= 1'b0;
      fb_v_r      <= 1'b0;
      sq_v_r      <= '0;
      cd_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      fa_v_r      <= in_valid;
      fb_v_r      <= fa_v_r;
      sq_v_r      <= {sq_v_r[SQ_STAGES-2:0], fb_v_r};
      cd_v_r      <= {cd_v_r[CORDIC_STAGES-1:0], sq_v_r[SQ_STAGES-1]};
      out_valid_r <= cd_v_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r  <= fa_nxt;
      fb_r  <= fa_r;
      mb_r  <= SQ_STAGES'(32'sd268435456 - sqr);
      for (int k = 0; k < SQ_STAGES; k++) sq_r[k] <= sq_nxt[k];
      for (int j = 0; j <= CORDIC_STAGES; j++) cd_r[j] <= cd_nxt[j];
      out_r <= out_nxt;
    end
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Y-X-Z Euler angle block. Rotation-matrix beats are sent
// through the input handshake. Each accepted beat is predicted by a fixed-point
// CORDIC model held here and queued. Each result beat is compared field by
// field with the oldest queued angle set. The run goes through directed
// corners, random matrices, a long output stall and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import rmeyxz_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t angles_due[$];
  int   errors;
  int   results_seen;
  int   idle_cycles;
  bit   burst_mode;
  bit   hold_request;
  bit   no_gaps_out;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 80;

  longint arc_deg [0:22] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1};

  rotation_matrix_to_euler_yxz dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint clamp_entry(input logic signed [15:0] v);
    longint w;
    w = v;
    if (w < -16384) w = -16384;
    if (w > 16384) w = 16384;
    return w;
  endfunction

  function automatic longint unsigned root_of(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint heading(input longint y, input longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + ((i < 23) ? arc_deg[i] : 0);
      end else begin
        x = x - dx; y = y + dy; z = z - ((i < 23) ? arc_deg[i] : 0);
      end
    end
    return z;
  endfunction

  function automatic longint to_scaled(input longint z, input longint lim);
    longint r;
    r = (z + 256) >>> 9;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic out_t euler_angles(input in_t d);
    out_t   o;
    longint c12, c02, c22, c10, c11, c01, c00;
    longint ax, ay, az, s, cs;
    c12 = clamp_entry(d.r12);
    c02 = clamp_entry(d.r02);
    c22 = clamp_entry(d.r22);
    c10 = clamp_entry(d.r10);
    c11 = clamp_entry(d.r11);
    c01 = clamp_entry(d.r01);
    c00 = clamp_entry(d.r00);
    o.gimbal_lock = 1'b0;
    if (c12 == -16384 || c12 == 16384) begin
      o.gimbal_lock = 1'b1;
      az = 0;
      ay = to_scaled(heading(-c01 * 16384, c00 * 16384), 23040);
      if (c12 == -16384) begin
        ax = 11520;
      end else begin
        ax = -11520;
        ay = -ay;
      end
    end else begin
      s  = -c12 * 16384;
      cs = longint'(root_of((64'd1 << 56) - longint'(s * s)));
      ax = to_scaled(heading(s, cs), 11520);
      ay = to_scaled(heading(c02 * 16384, c22 * 16384), 23040);
      az = to_scaled(heading(c10 * 16384, c11 * 16384), 23040);
    end
    o.angle_x = ax[14:0];
    o.angle_y = ay[15:0];
    o.angle_z = az[15:0];
    return o;
  endfunction

  task automatic send_matrix(input in_t d);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    angles_due = {angles_due, euler_angles(d)};
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    wait (angles_due.size() == 0);
    @(posedge clk);
  endtask

  function automatic in_t same_matrix(input logic signed [15:0] v);
    in_t d;
    d = '{v, v, v, v, v, v, v};
    return d;
  endfunction

  function automatic logic signed [15:0] pick_entry;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
    if (sel < 9) return 16'($urandom);
    return (sel[0]) ? 16'sd16384 : -16'sd16384;
  endfunction

  task automatic test_directed;
    in_t d;
    send_matrix('{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384});
    send_matrix(same_matrix(16'sh7FFF));
    send_matrix(same_matrix(16'sh8000));
    send_matrix(same_matrix(16'sd0));
    send_matrix(same_matrix(16'sd16384));
    send_matrix(same_matrix(-16'sd16384));
    send_matrix(same_matrix(16'sd16383));
    send_matrix(same_matrix(-16'sd16383));
    send_matrix('{-16'sd16384, 16'sd5, 16'sd9, 16'sd3, 16'sd1, 16'sd8000, 16'sd9000});
    send_matrix('{16'sd16384, 16'sd5, 16'sd9, 16'sd3, 16'sd1, 16'sd8000, 16'sd9000});
    send_matrix('{-16'sd20000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_matrix('{16'sd30000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd100});
    send_matrix('{16'sd0, 16'sd0, -16'sd16384, 16'sd0, -16'sd5, 16'sd0, 16'sd0});
    send_matrix('{16'sd100, -16'sd1, -16'sd16384, 16'sd1, -16'sd16384, 16'sd0, 16'sd0});
    send_matrix('{16'sd11585, 16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'sd0});
    send_matrix('{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    d = '{-16'sd1, -16'sd30000, 16'sd25000, 16'sd20000, -16'sd32768, 16'sd1, -16'sd1};
    send_matrix(d);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    in_t d;
    for (int n = 0; n < count; n++) begin
      if (n % 500 == 0) no_gaps_out = ~no_gaps_out;
      burst_mode = (n % 300) < 60;
      d.r12 = pick_entry();
      d.r02 = pick_entry();
      d.r22 = pick_entry();
      d.r10 = pick_entry();
      d.r11 = pick_entry();
      d.r01 = pick_entry();
      d.r00 = pick_entry();
      send_matrix(d);
    end
    burst_mode = 1'b0;
    no_gaps_out = 1'b0;
    wait_drained();
  endtask

  task automatic test_output_stall;
    hold_request = 1'b1;
    burst_mode = 1'b1;
    for (int n = 0; n < 150; n++)
      send_matrix('{pick_entry(), pick_entry(), pick_entry(), pick_entry(),
                    pick_entry(), pick_entry(), pick_entry()});
    burst_mode = 1'b0;
    wait_drained();
  endtask

  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = no_gaps_out ? 0 : $urandom_range(0, 5);
      if (gap > 0) out_ready <= 1'b0;
      repeat (gap) @(posedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (angles_due.size() == 0) begin
        $error("result beat with no expectation: %h", out_data);
        errors++;
      end else begin
        want = angles_due.pop_front();
        if (out_data.angle_x !== want.angle_x) begin
          $error("angle_x expected %0d got %0d", want.angle_x, out_data.angle_x);
          errors++;
        end
        if (out_data.angle_y !== want.angle_y) begin
          $error("angle_y expected %0d got %0d", want.angle_y, out_data.angle_y);
          errors++;
        end
        if (out_data.angle_z !== want.angle_z) begin
          $error("angle_z expected %0d got %0d", want.angle_z, out_data.angle_z);
          errors++;
        end
        if (out_data.gimbal_lock !== want.gimbal_lock) begin
          $error("gimbal_lock expected %0b got %0b", want.gimbal_lock,
                 out_data.gimbal_lock);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", angles_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    results_seen = 0;
    burst_mode = 1'b0;
    hold_request = 1'b0;
    no_gaps_out = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1750);
    test_output_stall();
    test_random(100);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (angles_due.size() != 0) begin
      $error("%0d expected results never arrived", angles_due.size());
      errors++;
    end
    $display("covered corners, gimbal lock, clamping, random matrices, output stall");
    $display("%0d results checked, %0d errors", results_seen, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rmeyxz_pkg.sv
rtl/core/rotation_matrix_to_euler_yxz.sv
tb/tb_top.sv
